@@ sv/ehp_pkg.sv @@
package ehp_pkg;

  localparam int MAX_EXT_HEADERS_DEF = 8;
  localparam int MAX_FRAME_BYTES_DEF = 65535;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam logic [15:0] TPID_CTAG  = 16'h8100;
  localparam logic [15:0] TPID_STAG  = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [4:0]  ETH_HDR_LEN = 5'd14;

  localparam logic [7:0] NH_HOPOPT = 8'd0;
  localparam logic [7:0] NH_ROUTE  = 8'd43;
  localparam logic [7:0] NH_FRAG   = 8'd44;
  localparam logic [7:0] NH_DSTOPT = 8'd60;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMP4  = 8'd1;
  localparam logic [7:0] PROTO_ICMP6  = 8'd58;

  localparam logic [1:0] L3_NONE = 2'd0;
  localparam logic [1:0] L3_IPV4 = 2'd1;
  localparam logic [1:0] L3_IPV6 = 2'd2;

  localparam logic [1:0] L4_UNKNOWN = 2'd0;
  localparam logic [1:0] L4_TCP     = 2'd1;
  localparam logic [1:0] L4_UDP     = 2'd2;
  localparam logic [1:0] L4_ICMP    = 2'd3;

  localparam logic [4:0] FC_DSTMAC  = 5'd0;
  localparam logic [4:0] FC_SRCMAC  = 5'd1;
  localparam logic [4:0] FC_VLAN0   = 5'd2;
  localparam logic [4:0] FC_VLAN1   = 5'd3;
  localparam logic [4:0] FC_IPVER   = 5'd4;
  localparam logic [4:0] FC_TTL     = 5'd5;
  localparam logic [4:0] FC_IPID    = 5'd6;
  localparam logic [4:0] FC_FRAG    = 5'd7;
  localparam logic [4:0] FC_SRC_HI  = 5'd8;
  localparam logic [4:0] FC_SRC_LO  = 5'd9;
  localparam logic [4:0] FC_DST_HI  = 5'd10;
  localparam logic [4:0] FC_DST_LO  = 5'd11;
  localparam logic [4:0] FC_PROTO   = 5'd12;
  localparam logic [4:0] FC_SPORT   = 5'd13;
  localparam logic [4:0] FC_DPORT   = 5'd14;
  localparam logic [4:0] FC_SEQ     = 5'd15;
  localparam logic [4:0] FC_ACK     = 5'd16;
  localparam logic [4:0] FC_FLAGS   = 5'd17;
  localparam logic [4:0] FC_SUMMARY = 5'd18;

  typedef struct packed {
    logic        fld_v;
    logic [4:0]  fld_code;
    logic [63:0] fld_val;
    logic        sum_v;
    logic [4:0]  sum_val;
  } ehp_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ehp_qstat_t;

  function automatic logic is_ext(input logic [7:0] nh);
    return (nh == NH_HOPOPT) || (nh == NH_ROUTE) || (nh == NH_FRAG) || (nh == NH_DSTOPT);
  endfunction

  function automatic logic [1:0] kind_of(input logic [7:0] proto, input logic [1:0] l3);
    logic [1:0] k;
    k = L4_UNKNOWN;
    if (proto == PROTO_TCP) k = L4_TCP;
    else if (proto == PROTO_UDP) k = L4_UDP;
    else if ((l3 == L3_IPV4 && proto == PROTO_ICMP4) ||
             (l3 == L3_IPV6 && proto == PROTO_ICMP6)) k = L4_ICMP;
    return k;
  endfunction

  function automatic logic [1:0] l3_of(input logic [15:0] etype);
    logic [1:0] k;
    k = L3_NONE;
    if (etype == ETYPE_IPV4) k = L3_IPV4;
    else if (etype == ETYPE_IPV6) k = L3_IPV6;
    return k;
  endfunction

endpackage

@@ sv/ehp_front.sv @@
module ehp_front #(
  parameter int MAX_EXT_HEADERS = ehp_pkg::MAX_EXT_HEADERS_DEF,
  parameter int MAX_FRAME_BYTES = ehp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat,
  input  logic [7:0]        data_byte,
  input  logic              frame_end,
  output ehp_pkg::ehp_rec_t rec,
  output logic              rec_v
);

  localparam logic [15:0] MAX_POS = 16'(MAX_FRAME_BYTES);
  localparam logic [3:0]  MAX_EXT = 4'(MAX_EXT_HEADERS);

  logic [15:0] pos_r, pos_nxt;
  logic [1:0]  tag_r, tag_nxt;
  logic [1:0]  l3k_r, l3k_nxt;
  logic [4:0]  l3s_r, l3s_nxt;
  logic [15:0] l4s_r, l4s_nxt;
  logic [7:0]  nh_r, nh_nxt;
  logic [3:0]  extc_r, extc_nxt;
  logic [1:0]  l4k_r, l4k_nxt;
  logic        ff_r, ff_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic        fv;
  logic [4:0]  fcode;
  logic [63:0] fval;
  logic [15:0] v, off, o3, o4, l3s16;
  logic        adv;
  logic [7:0]  adv_nh;
  logic [16:0] adv_start;
  logic [3:0]  extc_inc;
  logic [17:0] need, l4len;
  logic        trunc;

  always_comb begin
    pos_nxt = pos_r; tag_nxt = tag_r; l3k_nxt = l3k_r; l3s_nxt = l3s_r;
    l4s_nxt = l4s_r; nh_nxt = nh_r; extc_nxt = extc_r; l4k_nxt = l4k_r;
    ff_nxt = ff_r; acc_nxt = acc_r;
    fv = 1'b0; fcode = ehp_pkg::FC_DSTMAC; fval = '0;
    adv = 1'b0; adv_nh = '0; adv_start = '0;
    v = '0; off = '0;
    l3s16 = {11'd0, l3s_r};
    o3 = pos_r - l3s16;
    o4 = pos_r - l4s_r;
    if (pos_r < MAX_POS) begin
      acc_nxt = {acc_r[55:0], data_byte};
      pos_nxt = pos_r + 16'd1;
      v = acc_nxt[15:0];
      if (pos_r < 16'd12) begin
        if (pos_r == 16'd5 || pos_r == 16'd11) begin
          fv = 1'b1;
          fcode = (pos_r == 16'd5) ? ehp_pkg::FC_DSTMAC : ehp_pkg::FC_SRCMAC;
          fval = {16'd0, acc_nxt[47:0]};
        end
      end else if (pos_r < l3s16) begin
        if (pos_r == 16'd13) begin
          if (v == ehp_pkg::TPID_CTAG) begin
            tag_nxt = 2'd1; l3s_nxt = 5'd18;
          end else if (v == ehp_pkg::TPID_STAG) begin
            tag_nxt = 2'd2; l3s_nxt = 5'd22;
          end else l3k_nxt = ehp_pkg::l3_of(v);
        end else if (pos_r == 16'd15 && tag_r != 2'd0) begin
          fv = 1'b1; fcode = ehp_pkg::FC_VLAN0; fval = {52'd0, v[11:0]};
        end else if (pos_r == 16'd17 && tag_r == 2'd1) begin
          l3k_nxt = ehp_pkg::l3_of(v);
        end else if (pos_r == 16'd19 && tag_r == 2'd2) begin
          fv = 1'b1; fcode = ehp_pkg::FC_VLAN1; fval = {52'd0, v[11:0]};
        end else if (pos_r == 16'd21 && tag_r == 2'd2) begin
          l3k_nxt = ehp_pkg::l3_of(v);
        end
      end else if (l3k_r == ehp_pkg::L3_NONE) begin
        fv = 1'b0;
      end else if (l3k_r == ehp_pkg::L3_IPV4 && o3 < 16'd20) begin
        case (o3[4:0])
          5'd0: begin
            l4s_nxt = (data_byte[3:0] >= 4'd5) ?
                      (l3s16 + {10'd0, data_byte[3:0], 2'b00}) : 16'd0;
            fv = 1'b1; fcode = ehp_pkg::FC_IPVER; fval = 64'd4;
          end
          5'd5: begin
            fv = 1'b1; fcode = ehp_pkg::FC_IPID; fval = {48'd0, v};
          end
          5'd7: begin
            off = {v[12:8], v[7:0], 3'b000};
            ff_nxt = (off == 16'd0);
            fv = 1'b1; fcode = ehp_pkg::FC_FRAG; fval = {47'd0, v[13], off};
          end
          5'd8: begin
            fv = 1'b1; fcode = ehp_pkg::FC_TTL; fval = {56'd0, data_byte};
          end
          5'd9: begin
            nh_nxt = data_byte;
            l4k_nxt = ehp_pkg::kind_of(data_byte, ehp_pkg::L3_IPV4);
            fv = 1'b1; fcode = ehp_pkg::FC_PROTO; fval = {56'd0, data_byte};
          end
          5'd15: begin
            fv = 1'b1; fcode = ehp_pkg::FC_SRC_LO; fval = {32'd0, acc_nxt[31:0]};
          end
          5'd19: begin
            fv = 1'b1; fcode = ehp_pkg::FC_DST_LO; fval = {32'd0, acc_nxt[31:0]};
          end
          default: fv = 1'b0;
        endcase
      end else if (l3k_r == ehp_pkg::L3_IPV6 && o3 < 16'd40) begin
        case (o3[5:0])
          6'd0: begin
            fv = 1'b1; fcode = ehp_pkg::FC_IPVER; fval = 64'd6;
          end
          6'd6: begin
            nh_nxt = data_byte;
            l4s_nxt = l3s16 + 16'd40;
            if (!ehp_pkg::is_ext(data_byte)) begin
              l4k_nxt = ehp_pkg::kind_of(data_byte, ehp_pkg::L3_IPV6);
              fv = 1'b1; fcode = ehp_pkg::FC_PROTO; fval = {56'd0, data_byte};
            end
          end
          6'd7: begin
            fv = 1'b1; fcode = ehp_pkg::FC_TTL; fval = {56'd0, data_byte};
          end
          6'd15: begin fv = 1'b1; fcode = ehp_pkg::FC_SRC_HI; fval = acc_nxt; end
          6'd23: begin fv = 1'b1; fcode = ehp_pkg::FC_SRC_LO; fval = acc_nxt; end
          6'd31: begin fv = 1'b1; fcode = ehp_pkg::FC_DST_HI; fval = acc_nxt; end
          6'd39: begin fv = 1'b1; fcode = ehp_pkg::FC_DST_LO; fval = acc_nxt; end
          default: fv = 1'b0;
        endcase
      end else if (l4s_r != 16'd0 && pos_r >= l4s_r) begin
        if (ehp_pkg::is_ext(nh_r)) begin
          if (l3k_r == ehp_pkg::L3_IPV6) begin
            if (o4 == 16'd0 && !ehp_pkg::is_ext(data_byte)) begin
              l4k_nxt = ehp_pkg::kind_of(data_byte, ehp_pkg::L3_IPV6);
              fv = 1'b1; fcode = ehp_pkg::FC_PROTO; fval = {56'd0, data_byte};
            end else if (o4 == 16'd1 && nh_r != ehp_pkg::NH_FRAG) begin
              adv = 1'b1; adv_nh = acc_nxt[15:8];
              adv_start = {1'b0, l4s_r} + {5'd0, ({1'b0, data_byte} + 9'd1), 3'b000};
            end else if (o4 == 16'd3 && nh_r == ehp_pkg::NH_FRAG) begin
              off = {v[15:3], 3'b000};
              if (off != 16'd0) begin
                ff_nxt = 1'b0; l4s_nxt = 16'd0;
              end else begin
                adv = 1'b1; adv_nh = acc_nxt[31:24];
                adv_start = {1'b0, l4s_r} + 17'd8;
              end
              fv = 1'b1; fcode = ehp_pkg::FC_FRAG; fval = {47'd0, v[0], off};
            end
          end
        end else if (l4k_r != ehp_pkg::L4_UNKNOWN && ff_r) begin
          if (l4k_r == ehp_pkg::L4_ICMP) begin
            if (o4 == 16'd0) begin
              fv = 1'b1; fcode = ehp_pkg::FC_SPORT; fval = {56'd0, data_byte};
            end else if (o4 == 16'd1) begin
              fv = 1'b1; fcode = ehp_pkg::FC_DPORT; fval = {56'd0, data_byte};
            end
          end else if (o4 == 16'd1) begin
            fv = 1'b1; fcode = ehp_pkg::FC_SPORT; fval = {48'd0, v};
          end else if (o4 == 16'd3) begin
            fv = 1'b1; fcode = ehp_pkg::FC_DPORT; fval = {48'd0, v};
          end else if (l4k_r == ehp_pkg::L4_TCP) begin
            if (o4 == 16'd7) begin
              fv = 1'b1; fcode = ehp_pkg::FC_SEQ; fval = {32'd0, acc_nxt[31:0]};
            end else if (o4 == 16'd11) begin
              fv = 1'b1; fcode = ehp_pkg::FC_ACK; fval = {32'd0, acc_nxt[31:0]};
            end else if (o4 == 16'd13) begin
              fv = 1'b1; fcode = ehp_pkg::FC_FLAGS; fval = {56'd0, data_byte};
            end
          end
        end
      end
    end
    extc_inc = (extc_r < 4'd15) ? (extc_r + 4'd1) : extc_r;
    if (adv) begin
      extc_nxt = extc_inc;
      nh_nxt = adv_nh;
      l4s_nxt = (adv_start > {1'b0, MAX_POS}) ? MAX_POS : adv_start[15:0];
      if (ehp_pkg::is_ext(adv_nh) && extc_inc >= MAX_EXT) l4s_nxt = 16'd0;
    end
  end

  always_comb begin
    l4len = (l4k_nxt == ehp_pkg::L4_TCP) ? 18'd14 :
            ((l4k_nxt == ehp_pkg::L4_UDP) ? 18'd4 : 18'd2);
    need = {13'd0, l3s_nxt};
    if (l3k_nxt == ehp_pkg::L3_IPV4) begin
      need = {13'd0, l3s_nxt} + 18'd20;
      if (l4s_nxt != 16'd0) begin
        if ({2'd0, l4s_nxt} > need) need = {2'd0, l4s_nxt};
        if (ff_nxt && l4k_nxt != ehp_pkg::L4_UNKNOWN) need = {2'd0, l4s_nxt} + l4len;
      end
    end else if (l3k_nxt == ehp_pkg::L3_IPV6) begin
      need = {13'd0, l3s_nxt} + 18'd40;
      if (l4s_nxt != 16'd0) begin
        if (ehp_pkg::is_ext(nh_nxt))
          need = {2'd0, l4s_nxt} + ((nh_nxt == ehp_pkg::NH_FRAG) ? 18'd4 : 18'd2);
        else if (ff_nxt && l4k_nxt != ehp_pkg::L4_UNKNOWN)
          need = {2'd0, l4s_nxt} + l4len;
        else if ({2'd0, l4s_nxt} > need)
          need = {2'd0, l4s_nxt};
      end
    end
    trunc = need > {2'd0, pos_nxt};
  end

  always_comb begin
    rec.fld_v    = fv;
    rec.fld_code = fcode;
    rec.fld_val  = fval;
    rec.sum_v    = frame_end;
    rec.sum_val  = {trunc, l4k_nxt, l3k_nxt};
    rec_v        = beat && (fv || frame_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat && frame_end)) begin
      pos_r <= '0; tag_r <= '0; l3k_r <= ehp_pkg::L3_NONE;
      l3s_r <= ehp_pkg::ETH_HDR_LEN; l4s_r <= '0; nh_r <= '0; extc_r <= '0;
      l4k_r <= ehp_pkg::L4_UNKNOWN; ff_r <= 1'b1; acc_r <= '0;
    end else if (beat) begin
      pos_r <= pos_nxt; tag_r <= tag_nxt; l3k_r <= l3k_nxt; l3s_r <= l3s_nxt;
      l4s_r <= l4s_nxt; nh_r <= nh_nxt; extc_r <= extc_nxt; l4k_r <= l4k_nxt;
      ff_r <= ff_nxt; acc_r <= acc_nxt;
    end
  end

endmodule

@@ sv/ehp_queue.sv @@
module ehp_queue #(
  parameter int DEPTH = ehp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ehp_pkg::ehp_rec_t  wr_rec,
  input  logic               pop,
  output ehp_pkg::ehp_rec_t  rd_rec,
  output ehp_pkg::ehp_qstat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  ehp_pkg::ehp_rec_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt = push ? ((wp_r == LAST) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt = pop  ? ((rp_r == LAST) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
    stat.full  = (cnt_r == CW'(DEPTH));
    stat.empty = (cnt_r == '0);
    rd_rec = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_rec;
  end

endmodule

@@ sv/ehp_back.sv @@
module ehp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ehp_pkg::ehp_rec_t  rd_rec,
  input  logic               q_empty,
  output logic               pop,
  output logic               sum_pend,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [71:0]        out_tdata,
  output logic               out_tlast
);

  logic        vld_r, vld_nxt;
  logic        pend_r, pend_nxt;
  logic [4:0]  psum_r, psum_nxt;
  logic [4:0]  code_r, code_nxt;
  logic [63:0] val_r, val_nxt;
  logic        last_r, last_nxt;
  logic        load;

  always_comb begin
    load = !vld_r || out_tready;
    pop = 1'b0;
    vld_nxt = vld_r; pend_nxt = pend_r; psum_nxt = psum_r;
    code_nxt = code_r; val_nxt = val_r; last_nxt = last_r;
    if (load) begin
      if (pend_r) begin
        vld_nxt = 1'b1; pend_nxt = 1'b0;
        code_nxt = ehp_pkg::FC_SUMMARY; val_nxt = {59'd0, psum_r}; last_nxt = 1'b1;
      end else if (!q_empty) begin
        pop = 1'b1; vld_nxt = 1'b1;
        if (rd_rec.fld_v) begin
          code_nxt = rd_rec.fld_code; val_nxt = rd_rec.fld_val; last_nxt = 1'b0;
          pend_nxt = rd_rec.sum_v; psum_nxt = rd_rec.sum_val;
        end else begin
          code_nxt = ehp_pkg::FC_SUMMARY; val_nxt = {59'd0, rd_rec.sum_val};
          last_nxt = 1'b1;
        end
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt; pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    psum_r <= psum_nxt; code_r <= code_nxt; val_r <= val_nxt; last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {3'd0, val_r, code_r};
  assign out_tlast  = last_r;
  assign sum_pend   = pend_r;

endmodule

@@ sv/ethernet_ip_header_parser_top.sv @@
// Ethernet / VLAN / IPv4 / IPv6 / L4 header parser.
// in_*: one frame byte per beat, in_tlast on the final byte of a frame.
// out_*: one beat per extracted field, tagged by field code; a summary beat
//   (l3 kind, l4 kind, truncated bit) with out_tlast closes every frame.
// Throughput: one input byte per cycle while in_tready is high. The final byte
//   of a frame that also completes a field yields two output beats: the field beat, then the summary.
// A field is registered into the queue and then into the output register
//   before it appears on out_*.
// The parser front end writes into a small record queue; the back end drains
//   it into a registered output stage. When the receiver stalls, the queue
//   fills and in_tready drops once it holds QUEUE_DEPTH records; bytes that
//   yield no result still need a free slot to be taken.
// Reset (rst_n low, synchronous) empties the queue and output stage and
//   returns the parser to the start of a frame.
module ethernet_ip_header_parser_top #(
  parameter int MAX_EXT_HEADERS = ehp_pkg::MAX_EXT_HEADERS_DEF,
  parameter int MAX_FRAME_BYTES = ehp_pkg::MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = ehp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [4:0] field_code, [68:5] field_value, [71:69] zero
  output logic        out_tlast
);

  ehp_pkg::ehp_rec_t   wr_rec, rd_rec;
  ehp_pkg::ehp_qstat_t qstat;
  logic beat, push, pop, sum_pend;

  assign in_tready = !qstat.full;
  assign beat = in_tvalid && in_tready;

  ehp_front #(
    .MAX_EXT_HEADERS(MAX_EXT_HEADERS),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .beat(beat), .data_byte(in_tdata),
    .frame_end(in_tlast), .rec(wr_rec), .rec_v(push)
  );

  ehp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_rec(wr_rec),
    .pop(pop), .rd_rec(rd_rec), .stat(qstat)
  );

  ehp_back u_back (
    .clk(clk), .rst_n(rst_n), .rd_rec(rd_rec), .q_empty(qstat.empty),
    .pop(pop), .sum_pend(sum_pend), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

`ifndef ASSERT_OFF
  a_tlast_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[4:0] == ehp_pkg::FC_SUMMARY)
    else $error("tlast on non-summary beat");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty");

  a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sum_pend |-> out_tvalid && !out_tlast)
    else $error("pending summary without field beat");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule
